[sv/olid_pkg.sv]
// Shared types and codes for the ordered list block.
package olid_pkg;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_LIST   = 2'd2;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BADPOS = 2'd1;
   localparam logic [1:0] ST_FULL   = 2'd2;
   localparam logic [1:0] ST_EMPTY  = 2'd3;

   localparam int POS_W = 5;
   localparam int VAL_W = 32;

   typedef struct packed {
      logic [1:0]       kind;
      logic             pos_zero;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] value;
   } cmd_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [VAL_W-1:0] entry_value;
      logic             last;
   } rsp_type;

endpackage

[sv/olid_fifo.sv]
// Two-entry queue used between the front, the back and the result port.
module olid_fifo #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] din,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] dout,
   output logic             empty
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign dout    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

[sv/olid_front.sv]
// Request side: accepts transactions, decodes them and queues commands.
module olid_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic [1:0]              req_opcode,
   input  logic signed [31:0]      req_value,
   input  logic [4:0]              req_position,
   input  logic                    cmd_pop,
   output olid_pkg::cmd_type       cmd,
   output logic                    cmd_valid
);
   import olid_pkg::*;

   cmd_type    cmd_d;
   logic       q_full;
   logic       q_empty;
   logic       q_push;

   always_comb begin
      cmd_d.kind     = req_opcode;
      cmd_d.pos_zero = (req_position == '0);
      cmd_d.position = req_position;
      cmd_d.value    = req_value;
   end

   // unused opcodes are taken and dropped here
   assign q_push    = req_push && (req_opcode != OP_UNUSED);
   assign req_full  = q_full;
   assign cmd_valid = !q_empty;

   olid_fifo #(
      .WIDTH ($bits(cmd_type))
   ) u_cmd_q (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .din   (cmd_d),
      .full  (q_full),
      .pop   (cmd_pop),
      .dout  (cmd),
      .empty (q_empty)
   );

endmodule

[sv/olid_back.sv]
// Execution side: list storage, entry count and the command sequencer.
module olid_back #(
   parameter int DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  olid_pkg::cmd_type cmd,
   input  logic              cmd_valid,
   output logic              cmd_pop,
   output olid_pkg::rsp_type rsp_data,
   output logic              rsp_push,
   input  logic              rsp_full
);
   import olid_pkg::*;

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > POS_W) ? CW : POS_W;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SHIFT = 2'd1;
   localparam logic [1:0] S_LIST  = 2'd2;

   logic [VAL_W-1:0] mem [DEPTH];
   logic [VAL_W-1:0] rd_ff;

   logic [1:0]       state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic [CW-1:0]    out_idx_ff, out_idx_in;
   logic             dv_ff, dv_in;
   logic             wr_pend_ff, wr_pend_in;
   logic [AW-1:0]    wr_addr_ff, wr_addr_in;

   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [VAL_W-1:0] mem_wdata;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic             push_now;
   logic             is_last;
   logic             pos_bad;

   assign rd_addr  = rd_idx_ff[AW-1:0];
   assign pos_bad  = cmd.pos_zero || (CMPW'(cmd.position) > CMPW'(count_ff));
   assign is_last  = ((out_idx_ff + CW'(1)) == count_ff);
   assign push_now = dv_ff && !rsp_full;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      rd_idx_in  = rd_idx_ff;
      out_idx_in = out_idx_ff;
      dv_in      = dv_ff;
      wr_pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      cmd_pop    = 1'b0;
      rsp_push   = 1'b0;
      rsp_data   = '0;
      rd_en      = 1'b0;
      mem_we     = wr_pend_ff;
      mem_waddr  = wr_addr_ff;
      mem_wdata  = rd_ff;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  OP_APPEND: begin
                     if (!rsp_full) begin
                        cmd_pop       = 1'b1;
                        rsp_push      = 1'b1;
                        rsp_data.last = 1'b1;
                        if (count_ff == CW'(DEPTH)) begin
                           rsp_data.status = ST_FULL;
                        end else begin
                           rsp_data.status = ST_OK;
                           mem_we          = 1'b1;
                           mem_waddr       = count_ff[AW-1:0];
                           mem_wdata       = cmd.value;
                           count_in        = count_ff + CW'(1);
                        end
                     end
                  end
                  OP_DELETE: begin
                     if (pos_bad) begin
                        if (!rsp_full) begin
                           cmd_pop         = 1'b1;
                           rsp_push        = 1'b1;
                           rsp_data.status = ST_BADPOS;
                           rsp_data.last   = 1'b1;
                        end
                     end else begin
                        state_in  = S_SHIFT;
                        rd_idx_in = CW'(cmd.position);
                     end
                  end
                  OP_LIST: begin
                     if (count_ff == '0) begin
                        if (!rsp_full) begin
                           cmd_pop         = 1'b1;
                           rsp_push        = 1'b1;
                           rsp_data.status = ST_EMPTY;
                           rsp_data.last   = 1'b1;
                        end
                     end else begin
                        state_in   = S_LIST;
                        rd_idx_in  = '0;
                        out_idx_in = '0;
                        dv_in      = 1'b0;
                     end
                  end
                  default: begin
                     cmd_pop = 1'b1;
                  end
               endcase
            end
         end
         S_SHIFT: begin
            // read entry i+1 now, write it to entry i next cycle
            if (rd_idx_ff < count_ff) begin
               rd_en      = 1'b1;
               wr_pend_in = 1'b1;
               wr_addr_in = AW'(rd_idx_ff - CW'(1));
               rd_idx_in  = rd_idx_ff + CW'(1);
            end else if (!rsp_full) begin
               count_in        = count_ff - CW'(1);
               cmd_pop         = 1'b1;
               rsp_push        = 1'b1;
               rsp_data.status = ST_OK;
               rsp_data.last   = 1'b1;
               state_in        = S_IDLE;
            end
         end
         S_LIST: begin
            if (push_now) begin
               rsp_push             = 1'b1;
               rsp_data.status      = ST_OK;
               rsp_data.entry_value = rd_ff;
               rsp_data.last        = is_last;
               out_idx_in           = out_idx_ff + CW'(1);
               if (is_last) begin
                  cmd_pop  = 1'b1;
                  state_in = S_IDLE;
               end
            end
            if ((rd_idx_ff < count_ff) && (!dv_ff || push_now)) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + CW'(1);
               dv_in     = 1'b1;
            end else if (push_now) begin
               dv_in = 1'b0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff  <= rd_idx_in;
      out_idx_ff <= out_idx_in;
      wr_addr_ff <= wr_addr_in;
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         dv_ff      <= 1'b0;
         wr_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dv_ff      <= dv_in;
         wr_pend_ff <= wr_pend_in;
      end
   end

endmodule

[sv/ordered_list_insert_delete_at_index.sv]
// Ordered list of signed 32-bit values with append, delete at index and list.
//
// Request channel: a transaction is taken when req_push is high and req_full
// is low. req_opcode 0 appends req_value, 1 deletes the entry at the
// one-based req_position, 2 lists every entry; opcode 3 is taken and dropped.
// Result channel: the oldest result is on rsp_status, rsp_entry_value and
// rsp_last while rsp_empty is low; it is taken when rsp_pop is high.
// rsp_last marks the final result of each request.
// Sequencing: an append or a rejected request is answered from the idle
// state; a delete moves each later entry down, one memory move per cycle;
// a list reads one entry per cycle from the storage read port while the
// result queue has room. The sequencer can start the cycle after a request
// is taken, and a result can be popped the cycle after the sequencer makes it.
// A two-entry command queue lets requests arrive while the sequencer works,
// and a two-entry result queue decouples the receiver.
// Reset empties the list and both queues; stored values need no clearing.
// When the receiver stalls, the result queue fills, the sequencer waits,
// then the command queue fills and req_full rises.
module ordered_list_insert_delete_at_index #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_position,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_entry_value,
   output logic               rsp_last
);
   import olid_pkg::*;

   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;
   rsp_type rsp_d;
   rsp_type rsp_q;
   logic    rsp_push;
   logic    rsp_full;

   olid_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_opcode   (req_opcode),
      .req_value    (req_value),
      .req_position (req_position),
      .cmd_pop      (cmd_pop),
      .cmd          (cmd),
      .cmd_valid    (cmd_valid)
   );

   olid_back #(
      .DEPTH (DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .rsp_data  (rsp_d),
      .rsp_push  (rsp_push),
      .rsp_full  (rsp_full)
   );

   olid_fifo #(
      .WIDTH ($bits(rsp_type))
   ) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (rsp_push),
      .din   (rsp_d),
      .full  (rsp_full),
      .pop   (rsp_pop),
      .dout  (rsp_q),
      .empty (rsp_empty)
   );

   assign rsp_status      = rsp_q.status;
   assign rsp_entry_value = rsp_q.entry_value;
   assign rsp_last        = rsp_q.last;

endmodule

[verif/olid_checker.sv]
// Checker for the ordered list block: predicts results per request and compares them in order.
module olid_checker #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   input  logic               req_full,
   input  logic [1:0]         req_opcode,
   input  logic signed [31:0] req_value,
   input  logic [4:0]         req_position,
   input  logic               rsp_empty,
   input  logic               rsp_pop,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_entry_value,
   input  logic               rsp_last,
   output int                 mismatches,
   output int                 results_due
);
   import olid_pkg::*;

   logic signed [31:0] stored[$];
   rsp_type            due_rsp[$];

   function automatic rsp_type result_of(input logic [1:0] status,
                                         input logic [31:0] value,
                                         input logic last);
      rsp_type r;
      r.status      = status;
      r.entry_value = value;
      r.last        = last;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
   endtask

   // Applies one accepted transaction to the shadow list and queues its results.
   task automatic apply_list_op(input logic [1:0] op, input logic signed [31:0] val,
                                input logic [4:0] pos);
      case (op)
         OP_APPEND: begin
            if (stored.size() >= DEPTH) begin
               due_rsp.push_back(result_of(ST_FULL, '0, 1'b1));
            end else begin
               stored.push_back(val);
               due_rsp.push_back(result_of(ST_OK, '0, 1'b1));
            end
         end
         OP_DELETE: begin
            if (pos == 0 || int'(pos) > stored.size()) begin
               due_rsp.push_back(result_of(ST_BADPOS, '0, 1'b1));
            end else begin
               stored.delete(int'(pos) - 1);
               due_rsp.push_back(result_of(ST_OK, '0, 1'b1));
            end
         end
         OP_LIST: begin
            if (stored.size() == 0) begin
               due_rsp.push_back(result_of(ST_EMPTY, '0, 1'b1));
            end else begin
               foreach (stored[i])
                  due_rsp.push_back(result_of(ST_OK, stored[i], i == stored.size() - 1));
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         stored.delete();
         due_rsp.delete();
         mismatches = 0;
      end else begin
         if (!rsp_empty && rsp_pop) begin
            if (due_rsp.size() == 0) begin
               report_mismatch($sformatf("unexpected transaction status %0d value %0d last %0b",
                                         rsp_status, rsp_entry_value, rsp_last));
            end else begin
               want = due_rsp.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, want.status));
               if (rsp_entry_value !== want.entry_value)
                  report_mismatch($sformatf("entry_value %0d, expected %0d",
                                            rsp_entry_value, $signed(want.entry_value)));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
            end
         end
         if (req_push && !req_full)
            apply_list_op(req_opcode, req_value, req_position);
      end
      results_due <= due_rsp.size();
   end

endmodule

[verif/tb_ordered_list_insert_delete_at_index.sv]
// Top testbench for the ordered list block: clock, reset, request and pop stimulus, verdict.
module tb_ordered_list_insert_delete_at_index;
   import olid_pkg::*;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_push = 1'b0;
   logic               req_full;
   logic [1:0]         req_opcode = OP_APPEND;
   logic signed [31:0] req_value = '0;
   logic [4:0]         req_position = '0;
   logic               rsp_empty;
   logic               rsp_pop = 1'b0;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_entry_value;
   logic               rsp_last;

   int  mismatches;
   int  results_due;
   int  items_sent = 0;
   int  hold_left = 0;
   bit  held = 1'b0;
   wire calm = (items_sent >= 100 && items_sent < 160);

   ordered_list_insert_delete_at_index dut (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_last        (rsp_last)
   );

   olid_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_opcode      (req_opcode),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_status      (rsp_status),
      .rsp_entry_value (rsp_entry_value),
      .rsp_last        (rsp_last),
      .mismatches      (mismatches),
      .results_due     (results_due)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Receiver: random pops, one long hold-off to back the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else if (!held && items_sent >= 200) begin
         held      <= 1'b1;
         hold_left <= 80;
         rsp_pop   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_pop   <= 1'b0;
      end else begin
         rsp_pop <= calm || $urandom_range(0, 99) >= 14;
      end
   end

   task automatic send_item(input logic [1:0] op, input logic signed [31:0] val,
                            input logic [4:0] pos);
      while (!calm && $urandom_range(0, 99) < 14) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push     <= 1'b1;
      req_opcode   <= op;
      req_value    <= val;
      req_position <= pos;
      @(posedge clock);
      while (req_full) @(posedge clock);
      items_sent <= items_sent + 1;
   endtask

   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 19))
         0:       return 32'sh7fffffff;
         1:       return 32'sh80000000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [4:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70)      return 5'($urandom_range(1, 4));
      else if (r < 90) return 5'($urandom_range(0, 16));
      else             return 5'($urandom_range(17, 31));
   endfunction

   initial begin
      int r;
      int append_pct;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // empty list corner cases, ignored opcode
      send_item(OP_LIST, '0, '0);
      send_item(OP_DELETE, '0, 5'd1);
      send_item(OP_UNUSED, $urandom, 5'($urandom));
      // fill to capacity with extreme values first
      send_item(OP_APPEND, 32'sh7fffffff, '0);
      send_item(OP_APPEND, 32'sh80000000, '0);
      send_item(OP_APPEND, '0, '0);
      send_item(OP_APPEND, -32'sd1, '0);
      for (int i = 4; i < 16; i++)
         send_item(OP_APPEND, $urandom, '0);
      send_item(OP_APPEND, 32'sd5, 5'd31);
      send_item(OP_LIST, '0, '0);
      send_item(OP_DELETE, '0, 5'd31);
      send_item(OP_DELETE, '0, 5'd16);
      send_item(OP_DELETE, '0, 5'd1);
      send_item(OP_DELETE, '0, 5'd0);
      send_item(OP_LIST, '0, '0);

      for (int k = 0; k < 235; k++) begin
         append_pct = ((k / 40) % 2 == 0) ? 60 : 25;
         r = $urandom_range(0, 99);
         if (r < 3)
            send_item(OP_UNUSED, $urandom, 5'($urandom));
         else if (r < 3 + append_pct)
            send_item(OP_APPEND, pick_value(), 5'($urandom));
         else if (r < 90)
            send_item(OP_DELETE, $urandom, pick_position());
         else
            send_item(OP_LIST, $urandom, 5'($urandom));
      end
      req_push <= 1'b0;

      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin
      #200000;
      $display("FAILURE");
      $finish;
   end

endmodule
